// File: rtl/raster_interleave_byte_packer_top_macros.svh
// assertion macros for the raster interleave byte packer
// used by raster_interleave_byte_packer_top; expects clk and rst in scope
`ifndef RASTER_INTERLEAVE_BYTE_PACKER_TOP_MACROS_SVH
`define RASTER_INTERLEAVE_BYTE_PACKER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define RIBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define RIBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ribp_pkg.sv
// shared types, constants and helpers of the raster interleave byte packer
// no dependencies
`timescale 1ns / 1ps

package ribp_pkg;

  localparam int MAX_LINES   = 4096;
  localparam int MAX_SAMPLES = 4096;
  localparam int MAX_BANDS   = 1024;

  localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int SAMP_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  localparam int LCNT_W = 13;
  localparam int SCNT_W = 13;
  localparam int BCNT_W = 11;

  localparam int LS_W = $clog2(MAX_LINES * MAX_SAMPLES + 1);
  localparam int SB_W = $clog2(MAX_SAMPLES * MAX_BANDS + 1);

  localparam int ADDR_W = 37;
  localparam int DATA_W = 64;
  localparam int BYTES_W = 4;
  localparam int TDATA_W = 112;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TYPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN   = 3'd5;

  localparam logic [2:0] ELEM_U8  = 3'd0;
  localparam logic [2:0] ELEM_S16 = 3'd1;
  localparam logic [2:0] ELEM_S32 = 3'd2;
  localparam logic [2:0] ELEM_F32 = 3'd3;
  localparam logic [2:0] ELEM_F64 = 3'd4;
  localparam logic [2:0] ELEM_U16 = 3'd5;

  localparam logic [1:0] LAYOUT_BSQ = 2'd0;
  localparam logic [1:0] LAYOUT_BIL = 2'd1;
  localparam logic [1:0] LAYOUT_BIP = 2'd2;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [SAMP_W-1:0] samp;
    logic [BAND_W-1:0] band;
    logic              last;
    logic [DATA_W-1:0] raw;
  } item_t;

  typedef struct packed {
    logic [LCNT_W-1:0] nl;
    logic [SCNT_W-1:0] ns;
    logic [BCNT_W-1:0] nb;
    logic [LS_W-1:0]   ls_prod;
    logic [SB_W-1:0]   sb_prod;
    logic [1:0]        size_log;
    logic [1:0]        layout;
    logic              be;
  } cfg_t;

  function automatic logic [1:0] elem_size_log(input logic [2:0] t);
    logic [1:0] r;
    case (t)
      ELEM_S16, ELEM_U16: r = 2'd1;
      ELEM_S32, ELEM_F32: r = 2'd2;
      ELEM_F64:           r = 2'd3;
      default:            r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ribp_front.sv
// front end: accepts sample beats, steps the line/sample/band counters
// and flags the image's last sample; depends on ribp_pkg
`timescale 1ns / 1ps

module ribp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  ribp_pkg::cfg_t               cfg,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ribp_pkg::DATA_W-1:0]  s_tdata,
  input  logic                         fifo_full,
  output logic                         push,
  output ribp_pkg::item_t              push_item
);

  logic [ribp_pkg::LINE_W-1:0] line_index, line_index_next;
  logic [ribp_pkg::SAMP_W-1:0] sample_index, sample_index_next;
  logic [ribp_pkg::BAND_W-1:0] band_index, band_index_next;
  logic end_b, end_s, end_l;

  assign s_tready = !fifo_full;
  assign push     = s_tvalid && s_tready;

  assign end_b = ribp_pkg::BCNT_W'(band_index) >= (cfg.nb - ribp_pkg::BCNT_W'(1));
  assign end_s = ribp_pkg::SCNT_W'(sample_index) >= (cfg.ns - ribp_pkg::SCNT_W'(1));
  assign end_l = ribp_pkg::LCNT_W'(line_index) >= (cfg.nl - ribp_pkg::LCNT_W'(1));

  always_comb begin
    push_item.line = line_index;
    push_item.samp = sample_index;
    push_item.band = band_index;
    push_item.last = end_b && end_s && end_l;
    push_item.raw  = s_tdata;
  end

  always_comb begin
    line_index_next   = line_index;
    sample_index_next = sample_index;
    band_index_next   = band_index + 1'b1;
    if (end_b) begin
      band_index_next = '0;
      if (end_s) begin
        sample_index_next = '0;
        line_index_next   = end_l ? '0 : line_index + 1'b1;
      end else begin
        sample_index_next = sample_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_index   <= '0;
      sample_index <= '0;
      band_index   <= '0;
    end else if (push) begin
      line_index   <= line_index_next;
      sample_index <= sample_index_next;
      band_index   <= band_index_next;
    end
  end

endmodule

// File: rtl/ribp_fifo.sv
// short queue between front and back ends, FIFO_DEPTH entries of item_t
// depends on ribp_pkg
`timescale 1ns / 1ps

module ribp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ribp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output ribp_pkg::item_t rd_item
);

  ribp_pkg::item_t mem [ribp_pkg::FIFO_DEPTH];
  logic [ribp_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [ribp_pkg::FIFO_PTR_W:0]   fill, fill_next;

  assign full     = fill == (ribp_pkg::FIFO_PTR_W+1)'(ribp_pkg::FIFO_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_item  = mem[rd_ptr];

  always_comb begin
    fill_next = fill;
    case ({push, pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

endmodule

// File: rtl/ribp_back.sv
// back end: position products, address scaling and byte ordering,
// two stages ending in the output register; depends on ribp_pkg
`timescale 1ns / 1ps

module ribp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ribp_pkg::cfg_t                cfg,
  input  logic                          rd_valid,
  input  ribp_pkg::item_t               rd_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ribp_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);

  localparam int PA_W = ribp_pkg::LINE_W + ribp_pkg::LS_W;
  localparam int PB_W = ribp_pkg::SAMP_W + ribp_pkg::SCNT_W;
  localparam int PC_W = ribp_pkg::BAND_W + ribp_pkg::LS_W;

  function automatic logic [ribp_pkg::DATA_W-1:0] order_bytes(
    input logic [ribp_pkg::DATA_W-1:0] raw,
    input logic [1:0]                  lg,
    input logic                        be
  );
    logic [ribp_pkg::DATA_W-1:0] res;
    logic [3:0] size;
    logic [2:0] src;
    res  = '0;
    size = 4'd1 << lg;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < size) begin
        src = be ? 3'(size - 4'd1 - 4'(b)) : 3'(b);
        res[8*b +: 8] = raw[8*src +: 8];
      end
    end
    return res;
  endfunction

  logic [ribp_pkg::LS_W-1:0]   coef_a, coef_c;
  logic [ribp_pkg::SCNT_W-1:0] coef_b;
  logic [PA_W-1:0] prod_a;
  logic [PB_W-1:0] prod_b;
  logic [PC_W-1:0] prod_c;

  logic                        s1_valid;
  logic [PA_W-1:0]             s1_a;
  logic [PB_W-1:0]             s1_b;
  logic [PC_W-1:0]             s1_c;
  logic [ribp_pkg::DATA_W-1:0] s1_data;
  logic                        s1_last;
  logic                        s1_ready, s2_ready;

  logic [ribp_pkg::ADDR_W-1:0]  pos, addr;
  logic [ribp_pkg::ADDR_W-1:0]  out_addr;
  logic [ribp_pkg::DATA_W-1:0]  out_data;
  logic [ribp_pkg::BYTES_W-1:0] out_count;

  always_comb begin
    case (cfg.layout)
      ribp_pkg::LAYOUT_BSQ: begin
        coef_a = ribp_pkg::LS_W'(cfg.ns);
        coef_b = ribp_pkg::SCNT_W'(1);
        coef_c = cfg.ls_prod;
      end
      ribp_pkg::LAYOUT_BIL: begin
        coef_a = ribp_pkg::LS_W'(cfg.sb_prod);
        coef_b = ribp_pkg::SCNT_W'(1);
        coef_c = ribp_pkg::LS_W'(cfg.ns);
      end
      default: begin
        coef_a = ribp_pkg::LS_W'(cfg.sb_prod);
        coef_b = ribp_pkg::SCNT_W'(cfg.nb);
        coef_c = ribp_pkg::LS_W'(1);
      end
    endcase
  end

  assign prod_a = PA_W'(rd_item.line) * PA_W'(coef_a);
  assign prod_b = PB_W'(rd_item.samp) * PB_W'(coef_b);
  assign prod_c = PC_W'(rd_item.band) * PC_W'(coef_c);

  assign s2_ready = !m_tvalid || m_tready;
  assign s1_ready = !s1_valid || s2_ready;
  assign pop      = rd_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_a    <= prod_a;
      s1_b    <= prod_b;
      s1_c    <= prod_c;
      s1_data <= order_bytes(rd_item.raw, cfg.size_log, cfg.be);
      s1_last <= rd_item.last;
    end
  end

  // address wraps modulo 2^ADDR_W
  assign pos  = ribp_pkg::ADDR_W'(s1_a) + ribp_pkg::ADDR_W'(s1_b) + ribp_pkg::ADDR_W'(s1_c);
  assign addr = pos << cfg.size_log;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_addr  <= addr;
      out_data  <= s1_data;
      out_count <= ribp_pkg::BYTES_W'(1) << cfg.size_log;
      m_tlast   <= s1_last;
    end
  end

  assign m_tdata = {
    (ribp_pkg::TDATA_W - ribp_pkg::ADDR_W - ribp_pkg::DATA_W - ribp_pkg::BYTES_W)'(0),
    out_count, out_data, out_addr
  };

endmodule

// File: rtl/raster_interleave_byte_packer_top.sv
// Raster interleave byte packer, top level.
// Samples arrive on the s_ channel in line, sample, band order (band fastest),
// one raw 64-bit pattern per beat. Each beat yields one result beat on the m_
// channel: the byte address of the element in band-sequential, interleave-by-
// line or interleave-by-pixel layout, the element bytes in the chosen byte
// order, the byte count, and tlast on the image's final sample.
// The cfg_ channel writes the six registers by index; cfg_ready is always high
// and registers should only be written while no beat is in flight.
// A beat accepted on s_ is written into the queue, then passes the product stage
// and the output register before it is presented on m_.
// Throughput: one beat per cycle while m_tready is high, set by the single front
// counter step and the two-stage back pipeline that each move one beat a cycle.
// A four-entry queue parts front and back; when m_tready is low the output
// register holds, the pipeline fills and s_tready drops once the queue is full.
// Reset clears the counters, the queue and the pipeline valids, and loads the
// register reset values; no clearing pass is needed.
// Depends on ribp_pkg, ribp_front, ribp_fifo, ribp_back and the macros header.
`timescale 1ns / 1ps
`include "raster_interleave_byte_packer_top_macros.svh"

module raster_interleave_byte_packer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample_bits [63:0]
  input  logic [ribp_pkg::DATA_W-1:0]      s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // byte_address [36:0], data_bytes [100:37], byte_count [104:101], zero [111:105]
  output logic [ribp_pkg::TDATA_W-1:0]     m_tdata,
  // last_of_image
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ribp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ribp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [ribp_pkg::LCNT_W-1:0] line_count;
  logic [ribp_pkg::SCNT_W-1:0] sample_count;
  logic [ribp_pkg::BCNT_W-1:0] band_count;
  logic [2:0]                  element_type;
  logic [1:0]                  layout_mode;
  logic                        big_endian;

  logic [ribp_pkg::LCNT_W-1:0] nl;
  logic [ribp_pkg::SCNT_W-1:0] ns;
  logic [ribp_pkg::BCNT_W-1:0] nb;
  logic [ribp_pkg::LS_W-1:0]   ls_prod;
  logic [ribp_pkg::SB_W-1:0]   sb_prod;
  ribp_pkg::cfg_t              cfg;

  logic            push, pop, fifo_full, rd_valid;
  ribp_pkg::item_t push_item, rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= ribp_pkg::LCNT_W'(1);
      sample_count <= ribp_pkg::SCNT_W'(1);
      band_count   <= ribp_pkg::BCNT_W'(1);
      element_type <= ribp_pkg::ELEM_U8;
      layout_mode  <= ribp_pkg::LAYOUT_BIP;
      big_endian   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ribp_pkg::REG_LINE_COUNT:   line_count   <= cfg_data[ribp_pkg::LCNT_W-1:0];
        ribp_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[ribp_pkg::SCNT_W-1:0];
        ribp_pkg::REG_BAND_COUNT:   band_count   <= cfg_data[ribp_pkg::BCNT_W-1:0];
        ribp_pkg::REG_ELEMENT_TYPE: element_type <= cfg_data[2:0];
        ribp_pkg::REG_LAYOUT_MODE:  layout_mode  <= cfg_data[1:0];
        ribp_pkg::REG_BIG_ENDIAN:   big_endian   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (line_count == '0) begin
      nl = ribp_pkg::LCNT_W'(1);
    end else if (line_count > ribp_pkg::LCNT_W'(ribp_pkg::MAX_LINES)) begin
      nl = ribp_pkg::LCNT_W'(ribp_pkg::MAX_LINES);
    end else begin
      nl = line_count;
    end
    if (sample_count == '0) begin
      ns = ribp_pkg::SCNT_W'(1);
    end else if (sample_count > ribp_pkg::SCNT_W'(ribp_pkg::MAX_SAMPLES)) begin
      ns = ribp_pkg::SCNT_W'(ribp_pkg::MAX_SAMPLES);
    end else begin
      ns = sample_count;
    end
    if (band_count == '0) begin
      nb = ribp_pkg::BCNT_W'(1);
    end else if (band_count > ribp_pkg::BCNT_W'(ribp_pkg::MAX_BANDS)) begin
      nb = ribp_pkg::BCNT_W'(ribp_pkg::MAX_BANDS);
    end else begin
      nb = band_count;
    end
  end

  // count products are registered and follow the count registers in the cycle after
  always_ff @(posedge clk) begin
    ls_prod <= ribp_pkg::LS_W'(ribp_pkg::LS_W'(nl) * ribp_pkg::LS_W'(ns));
    sb_prod <= ribp_pkg::SB_W'(ribp_pkg::SB_W'(ns) * ribp_pkg::SB_W'(nb));
  end

  always_comb begin
    cfg.nl       = nl;
    cfg.ns       = ns;
    cfg.nb       = nb;
    cfg.ls_prod  = ls_prod;
    cfg.sb_prod  = sb_prod;
    cfg.size_log = ribp_pkg::elem_size_log(element_type);
    cfg.layout   = layout_mode;
    cfg.be       = big_endian;
  end

  ribp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  ribp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .rd_valid  (rd_valid),
    .rd_item   (rd_item)
  );

  ribp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rd_valid (rd_valid),
    .rd_item  (rd_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `RIBP_ASSERT_NOW(a_count_pow2, m_tvalid, $onehot(m_tdata[104:101]), "byte count not 1, 2, 4 or 8")
  `RIBP_ASSERT_NOW(a_one_byte_clean, m_tvalid && m_tdata[104:101] == 4'd1, m_tdata[100:45] == '0, "unused bytes set for one-byte element")
  `RIBP_ASSERT_NOW(a_two_byte_clean, m_tvalid && m_tdata[104:101] == 4'd2, m_tdata[100:53] == '0, "unused bytes set for two-byte element")
  `RIBP_ASSERT_NEXT(a_no_accept_when_full, s_tvalid && !s_tready && !m_tready && m_tvalid, m_tvalid, "output dropped while stalled")

endmodule
